// ----- hdl/layer_norm_forward_unit_defines.svh -----
// Assertion macros shared by the layer norm forward unit.
// Included by the RTL files that carry concurrent assertions.
`ifndef LAYER_NORM_FORWARD_UNIT_DEFINES_SVH
`define LAYER_NORM_FORWARD_UNIT_DEFINES_SVH
`ifndef SYNTH
`define LNF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define LNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LNF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LNF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/lnf_pkg.sv -----
// Constants, types and helpers for the layer norm forward unit.
// No dependencies.
package lnf_pkg;

   localparam int ROW_MAX_DEF    = 64;
   localparam int DATA_WIDTH_DEF = 16;
   localparam int CFG_LEN_W      = 7;
   localparam int EPS_W          = 16;
   localparam int RSTD_W         = 24;
   localparam int RECIP_SHIFT    = 48;
   localparam int RECIP_W        = RECIP_SHIFT + 1;
   localparam int CSR_IDX_W      = 4;
   localparam int CSR_DATA_W     = 16;

   localparam logic [RSTD_W-1:0] RSTD_MAX = {RSTD_W{1'b1}};

   localparam logic [CFG_LEN_W-1:0] ROW_LENGTH_RST = 7'd64;
   localparam logic [EPS_W-1:0]     EPSILON_RST    = 16'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_LENGTH = 4'd0,
      CSR_EPSILON    = 4'd1,
      CSR_USE_WEIGHT = 4'd2,
      CSR_USE_BIAS   = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

   // Divider width covering 2^48 / v, (nQ - S*S) / n^2 and |S| / n.
   function automatic int lnf_div_width(int dw, int cw);
      int m;
      m = RECIP_W;
      if (2 * dw + 2 * cw > m) m = 2 * dw + 2 * cw;
      return m;
   endfunction

endpackage

// ----- hdl/lnf_if.sv -----
// Handshake channels of the layer norm forward unit: input, result, register write.
// Depends on lnf_pkg.
interface lnf_req_if import lnf_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample;
   logic signed [DATA_WIDTH-1:0] gain;
   logic signed [DATA_WIDTH-1:0] offset;
   modport source (output valid, sample, gain, offset, input ready);
   modport sink (input valid, sample, gain, offset, output ready);
endinterface

interface lnf_rsp_if import lnf_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] normalized;
   logic signed [DATA_WIDTH-1:0] row_mean;
   logic [RSTD_W-1:0]            row_rstd;
   logic                         last_of_row;
   modport source (output valid, normalized, row_mean, row_rstd, last_of_row, input ready);
   modport sink (input valid, normalized, row_mean, row_rstd, last_of_row, output ready);
endinterface

interface lnf_csr_if import lnf_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/layer_norm_forward_unit.sv -----
// Layer norm forward unit top level: register file, front end, row queue, back end, row RAM.
// Depends on lnf_pkg, lnf_if, lnf_ram, lnf_front, lnf_job_queue, lnf_back.
//
// Normalizes rows of row_length signed Q8.8 elements. Elements load at one per cycle into
// one of two row banks; a finished row goes to a two-entry queue, so the next row loads
// while the back end works on the previous one (input stalls only when both banks are held).
// Per row the back end spends three passes of a shared bit-serial divider for mean, variance
// and 2^48/v, then a square root (one multiply and one compare per result bit); when v is zero
// the last pass and the root are skipped. Each emitted element then takes a RAM read, two
// multiplies, rounding and saturation.
// Results come out of an output register, one per element, with mean and rstd attached.
module layer_norm_forward_unit import lnf_pkg::*; #(
   parameter int ROW_MAX    = ROW_MAX_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lnf_req_if.sink   req_bus,
   lnf_rsp_if.source rsp_bus,
   lnf_csr_if.sink   csr_bus
);
   localparam int CNT_W  = $clog2(ROW_MAX + 1);
   localparam int ADDR_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
   localparam int JOB_W  = CNT_W + 3 * DATA_WIDTH + 2 * CNT_W;
   localparam int RAM_W  = 3 * DATA_WIDTH;

   logic [CFG_LEN_W-1:0] row_length_ff, row_length_in;
   logic [EPS_W-1:0]     epsilon_ff, epsilon_in;
   logic                 use_weight_ff, use_weight_in;
   logic                 use_bias_ff, use_bias_in;

   q_stat_type           q_stat;
   logic                 job_push, job_pop;
   logic [JOB_W-1:0]     push_data, head_data;
   logic                 ram_wr_en, ram_rd_en;
   logic [ADDR_W:0]      ram_wr_addr, ram_rd_addr;
   logic [RAM_W-1:0]     ram_wr_data, ram_rd_data;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      row_length_in = row_length_ff;
      epsilon_in    = epsilon_ff;
      use_weight_in = use_weight_ff;
      use_bias_in   = use_bias_ff;
      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_ROW_LENGTH: row_length_in = csr_bus.data[CFG_LEN_W-1:0];
            CSR_EPSILON:    epsilon_in    = csr_bus.data[EPS_W-1:0];
            CSR_USE_WEIGHT: use_weight_in = csr_bus.data[0];
            CSR_USE_BIAS:   use_bias_in   = csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RST;
         epsilon_ff    <= EPSILON_RST;
         use_weight_ff <= 1'b1;
         use_bias_ff   <= 1'b1;
      end else begin
         row_length_ff <= row_length_in;
         epsilon_ff    <= epsilon_in;
         use_weight_ff <= use_weight_in;
         use_bias_ff   <= use_bias_in;
      end
   end

   lnf_front #(.ROW_MAX(ROW_MAX), .DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .row_length  (row_length_ff),
      .q_stat      (q_stat),
      .job_push    (job_push),
      .job_data    (push_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   lnf_job_queue #(.JOB_W(JOB_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .pop       (job_pop),
      .head_data (head_data),
      .stat      (q_stat)
   );

   lnf_ram #(.WIDTH(RAM_W), .DEPTH(2 ** (ADDR_W + 1))) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lnf_back #(.ROW_MAX(ROW_MAX), .DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_data    (head_data),
      .q_stat      (q_stat),
      .job_pop     (job_pop),
      .epsilon     (epsilon_ff),
      .use_weight  (use_weight_ff),
      .use_bias    (use_bias_ff),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp         (rsp_bus)
   );
endmodule

// ----- hdl/lnf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lnf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/lnf_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lnf_pkg.
module lnf_divider import lnf_pkg::*; #(
   parameter int W = RECIP_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] quotient,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[W-1]};
      ge      = trial >= {1'b0, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? W'(trial - {1'b0, div_ff}) : W'(trial);
         quo_in = {quo_ff[W-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ----- hdl/lnf_front.sv -----
// Front end: accepts elements, stores them in the row bank, keeps the running sums.
// Depends on lnf_pkg and lnf_if.
module lnf_front import lnf_pkg::*; #(
   parameter int ROW_MAX    = ROW_MAX_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   lnf_req_if.sink               req,
   input  logic [CFG_LEN_W-1:0]  row_length,
   input  q_stat_type            q_stat,
   output logic                  job_push,
   output logic [$clog2(ROW_MAX+1)+3*DATA_WIDTH+2*$clog2(ROW_MAX+1)-1:0] job_data,
   output logic                  ram_wr_en,
   output logic [((ROW_MAX > 1) ? $clog2(ROW_MAX) : 1):0] ram_wr_addr,
   output logic [3*DATA_WIDTH-1:0] ram_wr_data
);
   localparam int CNT_W  = $clog2(ROW_MAX + 1);
   localparam int ADDR_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
   localparam int SUM_W  = DATA_WIDTH + CNT_W;
   localparam int SQ_W   = 2 * DATA_WIDTH + CNT_W;

   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic                    bank_ff, bank_in;
   logic [CFG_LEN_W-1:0]    len_full;
   logic [CNT_W-1:0]        len;
   logic                    accept;
   logic [CNT_W-1:0]        cnt_next;
   logic signed [2*DATA_WIDTH-1:0] x_sq;
   logic signed [SUM_W-1:0] sum_next;
   logic [SQ_W-1:0]         sq_next;

   always_comb begin
      if (row_length == '0) begin
         len_full = CFG_LEN_W'(1);
      end else if (row_length > CFG_LEN_W'(ROW_MAX)) begin
         len_full = CFG_LEN_W'(ROW_MAX);
      end else begin
         len_full = row_length;
      end
      len = CNT_W'(len_full);
   end

   assign req.ready   = !q_stat.full;
   assign accept      = req.valid && !q_stat.full;
   assign cnt_next    = cnt_ff + CNT_W'(1);
   assign x_sq        = req.sample * req.sample;
   assign sum_next    = sum_ff + SUM_W'(req.sample);
   assign sq_next     = sq_ff + SQ_W'($unsigned(x_sq));
   assign job_push    = accept && (cnt_next >= len);
   assign job_data    = {cnt_next, sum_next, sq_next};
   assign ram_wr_en   = accept;
   assign ram_wr_addr = {bank_ff, cnt_ff[ADDR_W-1:0]};
   assign ram_wr_data = {req.sample, req.gain, req.offset};

   always_comb begin
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      bank_in = bank_ff;
      if (job_push) begin
         cnt_in  = '0;
         sum_in  = '0;
         sq_in   = '0;
         bank_in = !bank_ff;
      end else if (accept) begin
         cnt_in = cnt_next;
         sum_in = sum_next;
         sq_in  = sq_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         bank_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         bank_ff <= bank_in;
      end
   end
endmodule

// ----- hdl/lnf_job_queue.sv -----
// Two-entry queue of finished rows (count, sum, square sum) between front and back.
// Depends on lnf_pkg.
module lnf_job_queue import lnf_pkg::*; #(
   parameter int JOB_W = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [JOB_W-1:0] push_data,
   input  logic             pop,
   output logic [JOB_W-1:0] head_data,
   output q_stat_type       stat
);
   logic [JOB_W-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data  = entry_ff[rd_ptr_ff];
   assign stat.valid = count_ff != 2'd0;
   assign stat.full  = count_ff == 2'd2;
endmodule

// ----- hdl/lnf_back.sv -----
// Back end: row statistics (mean, variance, rstd) and the per-element output pass.
// Depends on lnf_pkg, lnf_if, lnf_divider and the assertion macros.
`include "layer_norm_forward_unit_defines.svh"
module lnf_back import lnf_pkg::*; #(
   parameter int ROW_MAX    = ROW_MAX_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [$clog2(ROW_MAX+1)+3*DATA_WIDTH+2*$clog2(ROW_MAX+1)-1:0] job_data,
   input  q_stat_type            q_stat,
   output logic                  job_pop,
   input  logic [EPS_W-1:0]      epsilon,
   input  logic                  use_weight,
   input  logic                  use_bias,
   output logic                  ram_rd_en,
   output logic [((ROW_MAX > 1) ? $clog2(ROW_MAX) : 1):0] ram_rd_addr,
   input  logic [3*DATA_WIDTH-1:0] ram_rd_data,
   lnf_rsp_if.source             rsp
);
   localparam int DW     = DATA_WIDTH;
   localparam int CNT_W  = $clog2(ROW_MAX + 1);
   localparam int ADDR_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
   localparam int SUM_W  = DW + CNT_W;
   localparam int SQ_W   = 2 * DW + CNT_W;
   localparam int NQ_W   = SQ_W + CNT_W;
   localparam int SS_W   = 2 * SUM_W;
   localparam int DIV_W  = lnf_div_width(DW, CNT_W);
   localparam int BIT_W  = $clog2(RSTD_W);
   localparam int XD_W   = DW + 1;
   localparam int P1_W   = XD_W + RSTD_W + 1;
   localparam int T_W    = 32;
   localparam int P2_W   = T_W + DW;
   localparam int F_W    = P2_W + 1;

   localparam logic signed [P1_W-1:0] RND1 = P1_W'(32768);
   localparam logic signed [P1_W-1:0] T_HI = {{(P1_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [P1_W-1:0] T_LO = {{(P1_W-31){1'b1}}, {31{1'b0}}};
   localparam logic signed [P2_W-1:0] RND2 = P2_W'(128);
   localparam logic signed [F_W-1:0]  O_HI = {{(F_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [F_W-1:0]  O_LO = {{(F_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

   typedef enum logic [11:0] {
      S_IDLE   = 12'b0000_0000_0001,
      S_PROD   = 12'b0000_0000_0010,
      S_MEAN   = 12'b0000_0000_0100,
      S_VAR    = 12'b0000_0000_1000,
      S_RECIP  = 12'b0000_0001_0000,
      S_SQ_MUL = 12'b0000_0010_0000,
      S_SQ_CMP = 12'b0000_0100_0000,
      S_RD     = 12'b0000_1000_0000,
      S_M1     = 12'b0001_0000_0000,
      S_M2     = 12'b0010_0000_0000,
      S_M3     = 12'b0100_0000_0000,
      S_FIN    = 12'b1000_0000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic                    neg_ff, neg_in;
   logic [SUM_W-1:0]        abs_ff, abs_in;
   logic [NQ_W-1:0]         nq_ff, nq_in;
   logic [SS_W-1:0]         ss_ff, ss_in;
   logic [2*CNT_W-1:0]      nn_ff, nn_in;
   logic signed [DW-1:0]    mean_ff, mean_in;
   logic [RECIP_W-1:0]      q_ff, q_in;
   logic [RSTD_W-1:0]       r_ff, r_in;
   logic [BIT_W-1:0]        bit_ff, bit_in;
   logic [2*RSTD_W-1:0]     sq_ff, sq_in;
   logic [RSTD_W-1:0]       rstd_ff, rstd_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    bank_ff, bank_in;
   logic signed [P1_W-1:0]  p1_ff, p1_in;
   logic signed [T_W-1:0]   t1_ff, t1_in;
   logic signed [P2_W-1:0]  p2_ff, p2_in;
   logic signed [DW-1:0]    g_ff, g_in;
   logic signed [DW-1:0]    b_ff, b_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [DW-1:0]    out_norm_ff, out_norm_in;
   logic                    out_last_ff, out_last_in;
   logic signed [DW-1:0]    out_mean_ff;
   logic [RSTD_W-1:0]       out_rstd_ff;

   logic [CNT_W-1:0]        job_n;
   logic signed [SUM_W-1:0] job_sum;
   logic [SQ_W-1:0]         job_sq;
   logic                    div_start, div_busy, div_done;
   logic [DIV_W-1:0]        div_a, div_b, div_quo, div_rem;
   logic [SUM_W-1:0]        mean_mag;
   logic [DIV_W-1:0]        v_sum;
   logic [RSTD_W-1:0]       t_cur;
   logic signed [XD_W-1:0]  x_diff;
   logic signed [RSTD_W:0]  rstd_s;
   logic signed [P1_W-1:0]  p1_rnd;
   logic signed [P2_W-1:0]  tw;
   logic signed [F_W-1:0]   f_sum;
   logic                    out_free;
   logic                    is_last;
   logic                    div_wait;

   assign {job_n, job_sum, job_sq} = job_data;

   lnf_divider #(.W(DIV_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      // floor of a negative mean rounds the magnitude up
      mean_mag = div_quo[SUM_W-1:0] + SUM_W'(neg_ff && (div_rem != '0));
      v_sum    = div_quo + DIV_W'(epsilon);
      t_cur    = r_ff | (RSTD_W'(1) << bit_ff);
      x_diff   = XD_W'($signed(ram_rd_data[3*DW-1:2*DW])) - XD_W'(mean_ff);
      rstd_s   = $signed({1'b0, rstd_ff});
      p1_rnd   = (p1_ff + RND1) >>> 16;
      tw       = use_weight ? ((p2_ff + RND2) >>> 8) : P2_W'(t1_ff);
      f_sum    = F_W'(tw) + (use_bias ? F_W'(b_ff) : F_W'(0));
      out_free = !out_valid_ff || rsp.ready;
      is_last  = (idx_ff + CNT_W'(1)) == n_ff;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      abs_in       = abs_ff;
      nq_in        = nq_ff;
      ss_in        = ss_ff;
      nn_in        = nn_ff;
      mean_in      = mean_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      bit_in       = bit_ff;
      sq_in        = sq_ff;
      rstd_in      = rstd_ff;
      idx_in       = idx_ff;
      bank_in      = bank_ff;
      p1_in        = p1_ff;
      t1_in        = t1_ff;
      p2_in        = p2_ff;
      g_in         = g_ff;
      b_in         = b_ff;
      out_norm_in  = out_norm_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      div_start    = 1'b0;
      div_a        = '0;
      div_b        = '0;
      job_pop      = 1'b0;
      ram_rd_en    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_stat.valid) begin
               n_in     = job_n;
               neg_in   = job_sum < 0;
               abs_in   = (job_sum < 0) ? SUM_W'(-job_sum) : SUM_W'(job_sum);
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            nq_in     = NQ_W'(n_ff) * NQ_W'(job_sq);
            ss_in     = SS_W'(abs_ff) * SS_W'(abs_ff);
            nn_in     = (2*CNT_W)'(n_ff) * (2*CNT_W)'(n_ff);
            div_start = 1'b1;
            div_a     = DIV_W'(abs_ff);
            div_b     = DIV_W'(n_ff);
            state_in  = S_MEAN;
         end
         S_MEAN: begin
            if (div_done) begin
               mean_in   = neg_ff ? DW'(-mean_mag) : DW'(mean_mag);
               div_start = 1'b1;
               div_a     = (SS_W'(nq_ff) > ss_ff) ? DIV_W'(SS_W'(nq_ff) - ss_ff) : '0;
               div_b     = DIV_W'(nn_ff);
               state_in  = S_VAR;
            end
         end
         S_VAR: begin
            if (div_done) begin
               if (v_sum == '0) begin
                  rstd_in  = RSTD_MAX;
                  idx_in   = '0;
                  state_in = S_RD;
               end else begin
                  div_start = 1'b1;
                  div_a     = DIV_W'({1'b1, {RECIP_SHIFT{1'b0}}});
                  div_b     = v_sum;
                  state_in  = S_RECIP;
               end
            end
         end
         S_RECIP: begin
            if (div_done) begin
               q_in     = div_quo[RECIP_W-1:0];
               r_in     = '0;
               bit_in   = BIT_W'(RSTD_W - 1);
               state_in = S_SQ_MUL;
            end
         end
         S_SQ_MUL: begin
            sq_in    = (2*RSTD_W)'(t_cur) * (2*RSTD_W)'(t_cur);
            state_in = S_SQ_CMP;
         end
         S_SQ_CMP: begin
            if (RECIP_W'(sq_ff) <= q_ff) begin
               r_in = t_cur;
            end
            if (bit_ff == '0) begin
               rstd_in  = (RECIP_W'(sq_ff) <= q_ff) ? t_cur : r_ff;
               idx_in   = '0;
               state_in = S_RD;
            end else begin
               bit_in   = bit_ff - BIT_W'(1);
               state_in = S_SQ_MUL;
            end
         end
         S_RD: begin
            ram_rd_en = 1'b1;
            state_in  = S_M1;
         end
         S_M1: begin
            p1_in    = x_diff * rstd_s;
            g_in     = $signed(ram_rd_data[2*DW-1:DW]);
            b_in     = $signed(ram_rd_data[DW-1:0]);
            state_in = S_M2;
         end
         S_M2: begin
            // round to nearest, then clamp to a 32-bit signed value
            if (p1_rnd > T_HI) begin
               t1_in = T_W'(T_HI);
            end else if (p1_rnd < T_LO) begin
               t1_in = T_W'(T_LO);
            end else begin
               t1_in = T_W'(p1_rnd);
            end
            state_in = S_M3;
         end
         S_M3: begin
            p2_in    = t1_ff * g_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in  = is_last;
               if (f_sum > O_HI) begin
                  out_norm_in = DW'(O_HI);
               end else if (f_sum < O_LO) begin
                  out_norm_in = DW'(O_LO);
               end else begin
                  out_norm_in = DW'(f_sum);
               end
               if (is_last) begin
                  job_pop  = 1'b1;
                  bank_in  = !bank_ff;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign ram_rd_addr = {bank_ff, idx_ff[ADDR_W-1:0]};
   assign div_wait    = (state_ff == S_MEAN) || (state_ff == S_VAR) || (state_ff == S_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bank_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         out_valid_ff <= out_valid_in;
      end
      n_ff        <= n_in;
      neg_ff      <= neg_in;
      abs_ff      <= abs_in;
      nq_ff       <= nq_in;
      ss_ff       <= ss_in;
      nn_ff       <= nn_in;
      mean_ff     <= mean_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      bit_ff      <= bit_in;
      sq_ff       <= sq_in;
      rstd_ff     <= rstd_in;
      idx_ff      <= idx_in;
      p1_ff       <= p1_in;
      t1_ff       <= t1_in;
      p2_ff       <= p2_in;
      g_ff        <= g_in;
      b_ff        <= b_in;
      out_norm_ff <= out_norm_in;
      out_last_ff <= out_last_in;
      if (state_ff == S_FIN && out_free) begin
         out_mean_ff <= mean_ff;
         out_rstd_ff <= rstd_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.normalized  = out_norm_ff;
   assign rsp.row_mean    = out_mean_ff;
   assign rsp.row_rstd    = out_rstd_ff;
   assign rsp.last_of_row = out_last_ff;

   `LNF_ASSERT_IMPLY(a_pop_has_job, clock, reset, job_pop, q_stat.valid)
   `LNF_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_start, !div_busy)
   `LNF_ASSERT_NEXT(a_pop_to_idle, clock, reset, job_pop, state_ff == S_IDLE)
   `LNF_ASSERT_IMPLY(a_div_done_wait, clock, reset, div_done, div_wait)
endmodule
